FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-domain switch protector RTL.
// Both macros sample on clk; the first is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define PDSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PDSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pdsp_pkg.sv
// ----------------------------------------------------------------------------
// pdsp_pkg
// Types, codes and constants shared by the power-domain switch protector.
// ----------------------------------------------------------------------------
package pdsp_pkg;

    localparam int DOMAIN_COUNT = 8;
    localparam int DOMAIN_W     = $clog2(DOMAIN_COUNT);
    localparam int CMD_W        = 3;
    localparam int DATA_W       = 16;
    localparam int MASK_W       = 8;

    localparam logic [DATA_W-1:0] UV_RESET_MV        = 16'd6000;
    localparam logic [DATA_W-1:0] LOW_DRAW_LIMIT_MA  = 16'd500;
    localparam logic [DATA_W-1:0] MED_DRAW_LIMIT_MA  = 16'd1500;
    localparam logic [DATA_W-1:0] HIGH_DRAW_LIMIT_MA = 16'd3000;
    localparam logic [DATA_W-1:0] TRIP_MAX           = '1;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_COMMAND   = 2'd0,
        REQ_CURRENT   = 2'd1,
        REQ_BATTERY   = 2'd2,
        REQ_THRESHOLD = 2'd3
    } req_type_t;

    // Domain command codes; code 7 has no name but is still recorded.
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_NOCHANGE  = 3'd0;
    localparam cmd_t CMD_ENABLE    = 3'd1;
    localparam cmd_t CMD_DISABLE   = 3'd2;
    localparam cmd_t CMD_TOGGLE    = 3'd3;
    localparam cmd_t CMD_OCLATCH   = 3'd4;
    localparam cmd_t CMD_BATTLOW   = 3'd5;
    localparam cmd_t CMD_AUTOSTART = 3'd6;

    typedef struct packed {
        req_type_t           req_type;
        logic [DOMAIN_W-1:0] domain;
        cmd_t                command;
        logic [DATA_W-1:0]   value;
    } item_t;

    typedef struct packed {
        logic [MASK_W-1:0] switch_mask;
        logic [MASK_W-1:0] limited_mask;
        logic [DATA_W-1:0] trip_count;
        cmd_t              last_command;
        logic              shutdown_active;
    } result_t;

    // Overcurrent threshold each domain starts from, by load class.
    function automatic logic [DATA_W-1:0] default_threshold(input int unsigned idx);
        logic [DATA_W-1:0] thr;
        thr = LOW_DRAW_LIMIT_MA;
        if (idx == 1)
            thr = MED_DRAW_LIMIT_MA;
        else if (idx == 7)
            thr = HIGH_DRAW_LIMIT_MA;
        return thr;
    endfunction

endpackage

FILE: hdl/power_domain_switch_protector.sv
// ----------------------------------------------------------------------------
// power_domain_switch_protector
// Eight power-domain switches with overcurrent latching, trip counting and
// undervoltage shutdown that always spares domain 0.
//
//   Channel   Handshake                 Payload
//   request   req_valid / req_stall     req_type, domain, command, value
//   result    rsp_valid / rsp_stall     switch_mask, limited_mask, trip_count,
//                                       last_command, shutdown_active
//   config    undervoltage_we           undervoltage_data
//
// One transaction per cycle sustained while the result is not stalled. A request
// accepted into the input register has its result loaded into the result
// register by the state update, and it can be taken from there. The state
// update is a single combinational pass per request.
// Reset is asynchronous; all domains come up off with class default limits.
// A stalled result holds the pipeline; req_stall rises only while both the
// input and result registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module power_domain_switch_protector
    import pdsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                undervoltage_we,
    input  logic [DATA_W-1:0]   undervoltage_data,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          req_type,
    input  logic [DOMAIN_W-1:0] domain,
    input  cmd_t                command,
    input  logic [DATA_W-1:0]   value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [MASK_W-1:0]   switch_mask,
    output logic [MASK_W-1:0]   limited_mask,
    output logic [DATA_W-1:0]   trip_count,
    output cmd_t                last_command,
    output logic                shutdown_active
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;

    // Input register.
    pdsp_req_stage u_req_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .domain     (domain),
        .command    (command),
        .value      (value),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Domain state and update logic.
    pdsp_state_core u_state_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .uv_we   (undervoltage_we),
        .uv_data (undervoltage_data),
        .fire    (advance),
        .item    (item),
        .result  (result)
    );

    // Result register.
    pdsp_rsp_stage u_rsp_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .result          (result),
        .advance         (advance),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .switch_mask     (switch_mask),
        .limited_mask    (limited_mask),
        .trip_count      (trip_count),
        .last_command    (last_command),
        .shutdown_active (shutdown_active)
    );

endmodule

FILE: hdl/pdsp_req_stage.sv
// ----------------------------------------------------------------------------
// pdsp_req_stage
// Input register: captures one request transaction and holds it until the
// processing stage moves it on.
// ----------------------------------------------------------------------------
module pdsp_req_stage
    import pdsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [1:0]          req_type,
    input  logic [DOMAIN_W-1:0] domain,
    input  cmd_t                command,
    input  logic [DATA_W-1:0]   value,
    input  logic                advance,
    output logic                item_valid,
    output item_t               item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The held item blocks new input only while it cannot move on.
    assign req_stall  = valid_reg && !advance;
    assign take       = req_valid && !req_stall;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{req_type: req_type_t'(req_type), domain: domain,
                          command: command, value: value};
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/pdsp_state_core.sv
// ----------------------------------------------------------------------------
// pdsp_state_core
// Domain state and the single-pass update applied to it for one request.
// The result reflects the state after the update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdsp_state_core
    import pdsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              uv_we,
    input  logic [DATA_W-1:0] uv_data,
    input  logic              fire,
    input  item_t             item,
    output result_t           result
);

    logic [DATA_W-1:0]                    uv_reg;
    logic [DOMAIN_COUNT-1:0]              enable_reg,   enable_next;
    logic [DOMAIN_COUNT-1:0]              limited_reg,  limited_next;
    logic [DOMAIN_COUNT-1:0][DATA_W-1:0]  trip_reg,     trip_next;
    cmd_t [DOMAIN_COUNT-1:0]              cmd_reg,      cmd_next;
    logic [DOMAIN_COUNT-1:0][DATA_W-1:0]  thr_reg,      thr_next;
    logic [DATA_W-1:0]                    prev_mv_reg,  prev_mv_next;
    logic                                 shutdown_reg, shutdown_next;

    cmd_t                eff_cmd;
    logic [DOMAIN_W-1:0] d;
    logic                over_limit;
    logic                batt_low;

    assign d          = item.domain;
    assign over_limit = item.value >= thr_reg[d];
    assign batt_low   = (item.value <= uv_reg) && (prev_mv_reg <= uv_reg);

    // Latch-type commands fold onto disable and autostart onto enable.
    always_comb
    begin
        unique case (item.command)
            CMD_OCLATCH, CMD_BATTLOW: eff_cmd = CMD_DISABLE;
            CMD_AUTOSTART:            eff_cmd = CMD_ENABLE;
            default:                  eff_cmd = item.command;
        endcase
    end

    // Next state for the request being processed.
    always_comb
    begin
        enable_next   = enable_reg;
        limited_next  = limited_reg;
        trip_next     = trip_reg;
        cmd_next      = cmd_reg;
        thr_next      = thr_reg;
        prev_mv_next  = prev_mv_reg;
        shutdown_next = shutdown_reg;
        if (fire)
        begin
            unique case (item.req_type)
                REQ_COMMAND:
                begin
                    cmd_next[d] = item.command;
                    if (eff_cmd != CMD_NOCHANGE)
                    begin
                        if (eff_cmd == CMD_ENABLE)
                            enable_next[d] = 1'b1;
                        else if (eff_cmd == CMD_DISABLE)
                            enable_next[d] = 1'b0;
                        else if (eff_cmd == CMD_TOGGLE)
                            enable_next[d] = !enable_reg[d];
                        // An enabled domain loses its current-limited flag.
                        if (enable_next[d])
                            limited_next[d] = 1'b0;
                    end
                end
                REQ_CURRENT:
                begin
                    if (over_limit)
                    begin
                        cmd_next[d]    = CMD_OCLATCH;
                        enable_next[d] = 1'b0;
                        if (!limited_reg[d])
                        begin
                            limited_next[d] = 1'b1;
                            if (trip_reg[d] != TRIP_MAX)
                                trip_next[d] = trip_reg[d] + 1'b1;
                        end
                    end
                end
                REQ_BATTERY:
                begin
                    prev_mv_next  = item.value;
                    shutdown_next = batt_low;
                    // Entering shutdown drops every domain but domain 0.
                    if (batt_low && !shutdown_reg)
                    begin
                        for (int i = 1; i < DOMAIN_COUNT; i++)
                        begin
                            cmd_next[i]    = CMD_BATTLOW;
                            enable_next[i] = 1'b0;
                        end
                    end
                end
                REQ_THRESHOLD:
                begin
                    if (item.value != '0)
                        thr_next[d] = item.value;
                end
            endcase
        end
    end

    // Result as seen after the update.
    always_comb
    begin
        result.switch_mask     = MASK_W'(enable_next);
        result.limited_mask    = MASK_W'(limited_next);
        result.trip_count      = trip_next[d];
        result.last_command    = cmd_next[d];
        result.shutdown_active = shutdown_next;
    end

    // State registers and the undervoltage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uv_reg       <= UV_RESET_MV;
            enable_reg   <= '0;
            limited_reg  <= '0;
            trip_reg     <= '0;
            cmd_reg      <= '0;
            prev_mv_reg  <= '0;
            shutdown_reg <= 1'b0;
            for (int i = 0; i < DOMAIN_COUNT; i++)
            begin
                thr_reg[i] <= default_threshold(i);
            end
        end
        else
        begin
            if (uv_we)
                uv_reg <= uv_data;
            enable_reg   <= enable_next;
            limited_reg  <= limited_next;
            trip_reg     <= trip_next;
            cmd_reg      <= cmd_next;
            thr_reg      <= thr_next;
            prev_mv_reg  <= prev_mv_next;
            shutdown_reg <= shutdown_next;
        end
    end

    // Domain 0 is never switched by a battery sample.
    `PDSP_ASSERT(a_domain0_spared, fire && item.req_type == REQ_BATTERY |=> enable_reg[0] == $past(enable_reg[0]), "battery sample changed domain 0")
    // Entering shutdown leaves only domain 0 possibly enabled.
    `PDSP_ASSERT(a_shutdown_entry, fire && item.req_type == REQ_BATTERY && batt_low && !shutdown_reg |=> enable_reg[DOMAIN_COUNT-1:1] == '0, "shutdown left a domain enabled")
    // Only a current sample can raise a current-limited flag.
    `PDSP_ASSERT(a_flag_source, !(fire && item.req_type == REQ_CURRENT) |=> (limited_reg & ~$past(limited_reg)) == '0, "limited flag set without a current sample")
    // Trip counters move only on current samples.
    `PDSP_ASSERT(a_trip_source, !(fire && item.req_type == REQ_CURRENT) |=> $stable(trip_reg), "trip counter changed without a current sample")

endmodule

FILE: hdl/pdsp_rsp_stage.sv
// ----------------------------------------------------------------------------
// pdsp_rsp_stage
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module pdsp_rsp_stage
    import pdsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  result_t           result,
    output logic              advance,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [MASK_W-1:0] switch_mask,
    output logic [MASK_W-1:0] limited_mask,
    output logic [DATA_W-1:0] trip_count,
    output cmd_t              last_command,
    output logic              shutdown_active
);

    logic    valid_reg;
    result_t result_reg;

    // A new result may load when the register is empty or being emptied.
    assign advance = item_valid && (!valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign rsp_valid       = valid_reg;
    assign switch_mask     = result_reg.switch_mask;
    assign limited_mask    = result_reg.limited_mask;
    assign trip_count      = result_reg.trip_count;
    assign last_command    = result_reg.last_command;
    assign shutdown_active = result_reg.shutdown_active;

endmodule

FILE: verif/power_domain_switch_protector_checker.sv
// ----------------------------------------------------------------------------
// power_domain_switch_protector_checker
// Watches the request and result channels of the switch protector. It keeps
// its own copy of the switch, flag, counter and threshold state, predicts the
// status word for every accepted request and compares each accepted result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module power_domain_switch_protector_checker
    import pdsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                undervoltage_we,
    input  logic [DATA_W-1:0]   undervoltage_data,
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic [1:0]          req_type,
    input  logic [DOMAIN_W-1:0] domain,
    input  cmd_t                command,
    input  logic [DATA_W-1:0]   value,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [MASK_W-1:0]   switch_mask,
    input  logic [MASK_W-1:0]   limited_mask,
    input  logic [DATA_W-1:0]   trip_count,
    input  cmd_t                last_command,
    input  logic                shutdown_active,
    output int unsigned         fail_count,
    output int unsigned         outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the protector state.
    logic [DOMAIN_COUNT-1:0] enabled_domains;
    logic [DOMAIN_COUNT-1:0] limited_domains;
    logic [DATA_W-1:0]       trip_counts [DOMAIN_COUNT];
    cmd_t                    recorded_cmds [DOMAIN_COUNT];
    logic [DATA_W-1:0]       oc_thresholds [DOMAIN_COUNT];
    logic [DATA_W-1:0]       prev_battery_mv;
    logic                    in_shutdown;
    logic [DATA_W-1:0]       undervoltage_mv;

    // Status words predicted for requests whose results are still due.
    result_t status_q [$];

    // One line and one count per mismatch.
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] status mismatch: %s", $time, msg);
    endtask

    task automatic clear_model();
        int i;
        enabled_domains = '0;
        limited_domains = '0;
        prev_battery_mv = '0;
        in_shutdown     = 1'b0;
        undervoltage_mv = UV_RESET_MV;
        for (i = 0; i < DOMAIN_COUNT; i++)
        begin
            trip_counts[i]   = '0;
            recorded_cmds[i] = CMD_NOCHANGE;
            if (i == 1)
                oc_thresholds[i] = MED_DRAW_LIMIT_MA;
            else if (i == 7)
                oc_thresholds[i] = HIGH_DRAW_LIMIT_MA;
            else
                oc_thresholds[i] = LOW_DRAW_LIMIT_MA;
        end
    endtask

    // Records the raw command, folds the protective codes onto enable and
    // disable, and clears the limited flag of a domain that ends up on.
    function automatic void switch_command(input int unsigned d, input cmd_t cmd);
        cmd_t action;
        recorded_cmds[d] = cmd;
        action = cmd;
        if (cmd == CMD_OCLATCH || cmd == CMD_BATTLOW)
            action = CMD_DISABLE;
        if (cmd == CMD_AUTOSTART)
            action = CMD_ENABLE;
        if (action != CMD_NOCHANGE)
        begin
            if (action == CMD_ENABLE)
                enabled_domains[d] = 1'b1;
            else if (action == CMD_DISABLE)
                enabled_domains[d] = 1'b0;
            else if (action == CMD_TOGGLE)
                enabled_domains[d] = ~enabled_domains[d];
            if (enabled_domains[d])
                limited_domains[d] = 1'b0;
        end
    endfunction

    // Applies one request to the shadow state and returns the status word after it.
    function automatic result_t apply_request(input item_t it);
        result_t     status;
        int unsigned d;
        int unsigned i;
        logic        was_shutdown;
        d = it.domain;
        case (it.req_type)
            REQ_COMMAND:
                switch_command(d, it.command);
            REQ_CURRENT:
                if (it.value >= oc_thresholds[d])
                begin
                    switch_command(d, CMD_OCLATCH);
                    if (!limited_domains[d])
                    begin
                        limited_domains[d] = 1'b1;
                        if (trip_counts[d] != TRIP_MAX)
                            trip_counts[d] = trip_counts[d] + 1'b1;
                    end
                end
            REQ_BATTERY:
            begin
                was_shutdown    = in_shutdown;
                in_shutdown     = (it.value <= undervoltage_mv) &&
                                  (prev_battery_mv <= undervoltage_mv);
                prev_battery_mv = it.value;
                // Entering shutdown turns off every domain but domain 0.
                if (in_shutdown && !was_shutdown)
                    for (i = 1; i < DOMAIN_COUNT; i++)
                        switch_command(i, CMD_BATTLOW);
            end
            default:
                if (it.value != '0)
                    oc_thresholds[d] = it.value;
        endcase
        status.switch_mask     = enabled_domains;
        status.limited_mask    = limited_domains;
        status.trip_count      = trip_counts[d];
        status.last_command    = recorded_cmds[d];
        status.shutdown_active = in_shutdown;
        return status;
    endfunction

    // Predict on every accepted request, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        item_t   req;
        result_t want;
        if (!rst_n)
        begin
            clear_model();
            status_q.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (undervoltage_we)
                undervoltage_mv = undervoltage_data;
            if (req_valid && !req_stall)
            begin
                req.req_type = req_type_t'(req_type);
                req.domain   = domain;
                req.command  = command;
                req.value    = value;
                status_q.push_back(apply_request(req));
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (status_q.size() == 0)
                    report_mismatch("result transaction with no request outstanding");
                else
                begin
                    want = status_q.pop_front();
                    if (switch_mask !== want.switch_mask)
                        report_mismatch($sformatf("switch_mask %h, expected %h",
                                                  switch_mask, want.switch_mask));
                    if (limited_mask !== want.limited_mask)
                        report_mismatch($sformatf("limited_mask %h, expected %h",
                                                  limited_mask, want.limited_mask));
                    if (trip_count !== want.trip_count)
                        report_mismatch($sformatf("trip_count %0d, expected %0d",
                                                  trip_count, want.trip_count));
                    if (last_command !== want.last_command)
                        report_mismatch($sformatf("last_command %0d, expected %0d",
                                                  last_command, want.last_command));
                    if (shutdown_active !== want.shutdown_active)
                        report_mismatch($sformatf("shutdown_active %b, expected %b",
                                                  shutdown_active, want.shutdown_active));
                end
            end
            outstanding <= status_q.size();
        end
    end

endmodule

FILE: verif/power_domain_switch_protector_tb.sv
// ----------------------------------------------------------------------------
// power_domain_switch_protector_tb
// Drives the switch protector with a directed sequence and four randomized
// phases under different sender idling, receiver stalling and undervoltage
// settings; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module power_domain_switch_protector_tb
    import pdsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned PHASE_ITEMS     = 300;
    localparam int unsigned HOLD_OFF_CYCLES = 60;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam cmd_t        CMD_UNUSED      = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                undervoltage_we = 1'b0;
    logic [DATA_W-1:0]   undervoltage_data = '0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_type_t           req_type = REQ_COMMAND;
    logic [DOMAIN_W-1:0] domain = '0;
    cmd_t                command = CMD_NOCHANGE;
    logic [DATA_W-1:0]   value = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [MASK_W-1:0]   switch_mask;
    logic [MASK_W-1:0]   limited_mask;
    logic [DATA_W-1:0]   trip_count;
    cmd_t                last_command;
    logic                shutdown_active;

    int unsigned         fail_count;
    int unsigned         outstanding;
    int unsigned         cycle_count = 0;
    int unsigned         idle_pct = 0;
    int unsigned         stall_pct = 0;
    logic                hold_off = 1'b0;
    logic                pressure_go = 1'b0;
    logic [DATA_W-1:0]   uv_setting = UV_RESET_MV;

    power_domain_switch_protector u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .undervoltage_we   (undervoltage_we),
        .undervoltage_data (undervoltage_data),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req_type          (req_type),
        .domain            (domain),
        .command           (command),
        .value             (value),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .switch_mask       (switch_mask),
        .limited_mask      (limited_mask),
        .trip_count        (trip_count),
        .last_command      (last_command),
        .shutdown_active   (shutdown_active)
    );

    power_domain_switch_protector_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .undervoltage_we   (undervoltage_we),
        .undervoltage_data (undervoltage_data),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req_type          (req_type),
        .domain            (domain),
        .command           (command),
        .value             (value),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .switch_mask       (switch_mask),
        .limited_mask      (limited_mask),
        .trip_count        (trip_count),
        .last_command      (last_command),
        .shutdown_active   (shutdown_active),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("power_domain_switch_protector regression: fail");
            $finish;
        end
    end

    // Result side: random stalls plus the long hold-off when it is active.
    always @(posedge clk)
    begin
        rsp_stall <= hold_off || ($urandom_range(99, 0) < stall_pct);
    end

    // Long receiver hold-off so the pipeline fills and the block stalls its input.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offers one request transaction and returns at the edge that accepts it.
    task automatic send_request(input req_type_t rt, input logic [DOMAIN_W-1:0] d,
                                input cmd_t c, input logic [DATA_W-1:0] v);
        bit took;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        domain    <= d;
        command   <= c;
        value     <= v;
        // Inputs only move at rising edges, so the stall seen mid-cycle is the one sampled.
        do
        begin
            @(negedge clk);
            took = !req_stall;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Waits until every result is back, then writes the undervoltage level.
    task automatic set_undervoltage(input logic [DATA_W-1:0] mv);
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
        undervoltage_we   <= 1'b1;
        undervoltage_data <= mv;
        @(posedge clk);
        undervoltage_we   <= 1'b0;
        uv_setting = mv;
    endtask

    // Random request with values clustered around thresholds and the undervoltage level.
    task automatic send_random_request();
        req_type_t         rt;
        logic [DATA_W-1:0] v;
        int unsigned       roll;
        int unsigned       lo;
        int unsigned       hi;
        roll = $urandom_range(99, 0);
        v    = DATA_W'($urandom);
        if (roll < 40)
            rt = REQ_COMMAND;
        else if (roll < 70)
        begin
            rt = REQ_CURRENT;
            if ($urandom_range(99, 0) < 65)
                v = DATA_W'($urandom_range(3500, 0));
        end
        else if (roll < 90)
        begin
            rt = REQ_BATTERY;
            lo = (uv_setting > 64) ? uv_setting - 64 : 0;
            hi = (uv_setting < 65471) ? uv_setting + 64 : 65535;
            if ($urandom_range(99, 0) < 60)
                v = DATA_W'($urandom_range(hi, lo));
        end
        else
        begin
            rt   = REQ_THRESHOLD;
            roll = $urandom_range(99, 0);
            if (roll < 10)
                v = '0;
            else if (roll < 70)
                v = DATA_W'($urandom_range(4000, 1));
        end
        send_request(rt, DOMAIN_W'($urandom_range(DOMAIN_COUNT - 1, 0)),
                     cmd_t'($urandom_range(7, 0)), v);
    endtask

    // Main sequence.
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_undervoltage(UV_RESET_MV);

        // Directed: every command, threshold edges, zero threshold, shutdown entry and exit.
        send_request(REQ_COMMAND,   3'd0, CMD_ENABLE,    16'd0);
        send_request(REQ_COMMAND,   3'd7, CMD_AUTOSTART, 16'hFFFF);
        send_request(REQ_CURRENT,   3'd0, CMD_NOCHANGE,  16'd499);
        send_request(REQ_CURRENT,   3'd0, CMD_NOCHANGE,  16'd500);
        send_request(REQ_CURRENT,   3'd0, CMD_UNUSED,    16'hFFFF);
        send_request(REQ_COMMAND,   3'd0, CMD_TOGGLE,    16'd0);
        send_request(REQ_COMMAND,   3'd0, CMD_DISABLE,   16'd0);
        send_request(REQ_COMMAND,   3'd3, CMD_NOCHANGE,  16'd0);
        send_request(REQ_COMMAND,   3'd7, CMD_OCLATCH,   16'd0);
        send_request(REQ_COMMAND,   3'd1, CMD_BATTLOW,   16'd0);
        send_request(REQ_CURRENT,   3'd1, CMD_NOCHANGE,  16'd1500);
        send_request(REQ_COMMAND,   3'd1, CMD_UNUSED,    16'd0);
        send_request(REQ_COMMAND,   3'd1, CMD_ENABLE,    16'd0);
        send_request(REQ_COMMAND,   3'd1, CMD_UNUSED,    16'd0);
        send_request(REQ_THRESHOLD, 3'd2, CMD_NOCHANGE,  16'd0);
        send_request(REQ_THRESHOLD, 3'd2, CMD_NOCHANGE,  16'd1);
        send_request(REQ_CURRENT,   3'd2, CMD_NOCHANGE,  16'd1);
        send_request(REQ_THRESHOLD, 3'd5, CMD_NOCHANGE,  16'hFFFF);
        send_request(REQ_CURRENT,   3'd5, CMD_NOCHANGE,  16'hFFFF);
        send_request(REQ_COMMAND,   3'd0, CMD_AUTOSTART, 16'd0);
        send_request(REQ_COMMAND,   3'd6, CMD_AUTOSTART, 16'd0);
        send_request(REQ_BATTERY,   3'd0, CMD_NOCHANGE,  16'd7000);
        send_request(REQ_BATTERY,   3'd4, CMD_NOCHANGE,  16'd6000);
        send_request(REQ_BATTERY,   3'd2, CMD_NOCHANGE,  16'd0);
        send_request(REQ_BATTERY,   3'd7, CMD_NOCHANGE,  16'd100);
        send_request(REQ_BATTERY,   3'd1, CMD_NOCHANGE,  16'hFFFF);

        // Random phases: flat out with a long hold-off, sender gaps, receiver stalls, both.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    set_undervoltage(DATA_W'($urandom_range(12000, 1000)));
                    idle_pct    <= 0;
                    stall_pct   <= 0;
                    pressure_go <= 1'b1;
                end
                1:
                begin
                    set_undervoltage(16'd0);
                    idle_pct  <= 63;
                    stall_pct <= 0;
                end
                2:
                begin
                    set_undervoltage(16'hFFFF);
                    idle_pct  <= 0;
                    stall_pct <= 63;
                end
                default:
                begin
                    set_undervoltage(DATA_W'($urandom));
                    idle_pct  <= 18;
                    stall_pct <= 18;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
        end

        // Drain and give the verdict.
        req_valid <= 1'b0;
        stall_pct <= 0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("power_domain_switch_protector regression: pass");
        else
            $display("power_domain_switch_protector regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pdsp_pkg.sv
hdl/pdsp_req_stage.sv
hdl/pdsp_state_core.sv
hdl/pdsp_rsp_stage.sv
hdl/power_domain_switch_protector.sv
verif/power_domain_switch_protector_checker.sv
verif/power_domain_switch_protector_tb.sv
